// ===== hdl/lfr_pkg.sv =====
// shared types, widths and command codes for the lru frame replacer
package lfr_pkg;

   localparam int ID_W  = 6;
   localparam int CNT_W = 7;
   localparam int CMD_W = 2;
   localparam int CSR_W = 7;

   localparam int MAX_FRAMES_DEF = 64;

   localparam logic [CSR_W-1:0] ACTIVE_RESET = 7'd64;

   // largest list size that the id space allows
   localparam logic [CNT_W-1:0] SIZE_CAP = CNT_W'(2 ** ID_W);

   localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

   typedef logic [ID_W-1:0]  frame_id_type;
   typedef logic [CNT_W-1:0] count_type;

endpackage

// ===== hdl/lfr_ram.sv =====
// generic simple dual port ram with registered read
module lfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lru_frame_replacer_top.sv =====
// lru frame replacer: doubly linked eviction list held in two rams
// result: the strobe is registered from the exec state, which follows the read state, or from the fix state
//   for a pin that unlinks a frame other than the newest one
// sequence: a request goes through accept, ram read and update before the next is taken, such a pin
//   adds a fix step, as its second back-link write needs a cycle of its own on the single write port
// reset: synchronous; afterwards busy stays high while a sweep clears the listed bit of
//   every frame, csr writes are taken throughout
// the receiver cannot stall: each result is shown for exactly one cycle
module lru_frame_replacer_top #(
   parameter int MAX_FRAMES = lfr_pkg::MAX_FRAMES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [lfr_pkg::CMD_W-1:0] req_cmd,
   input  logic [lfr_pkg::ID_W-1:0]  req_frame_id,
   // result channel
   output logic                      rsp_strobe,
   output logic                      rsp_changed,
   output logic [lfr_pkg::ID_W-1:0]  rsp_victim_frame,
   output logic [lfr_pkg::CNT_W-1:0] rsp_list_size,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [lfr_pkg::CSR_W-1:0] csr_wr_data
);

   import lfr_pkg::*;

   localparam int AW    = $clog2(MAX_FRAMES);
   localparam int BACK_W = ID_W + 1;   // listed bit plus back link

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_FIX   = 3'd4;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAMES - 1);

   // map a frame id onto a ram address (ids beyond the depth are filtered first)
   function automatic logic [AW-1:0] to_addr(input frame_id_type v);
      to_addr = AW'({{AW{1'b0}}, v});
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   frame_id_type     id_ff, id_in;
   frame_id_type     head_ff, head_in;
   frame_id_type     tail_ff, tail_in;
   count_type        count_ff, count_in;
   logic [CSR_W-1:0] active_ff;
   logic [AW-1:0]    clr_ff, clr_in;
   frame_id_type     link_ff, link_in;     // forward link of a frame being unlinked
   frame_id_type     back_ff, back_in;     // back link of a frame being unlinked

   logic             rsp_strobe_ff, rsp_fire;
   logic             rsp_changed_ff, rsp_changed_in;
   frame_id_type     rsp_victim_ff, rsp_victim_in;
   count_type        rsp_size_ff;

   // forward link ram: next newer frame
   logic             next_we;
   logic [AW-1:0]    next_waddr;
   frame_id_type     next_wdata;
   frame_id_type     next_rd;
   // back link ram: {listed, next older frame}
   logic             back_we;
   logic [AW-1:0]    back_waddr;
   logic [BACK_W-1:0] back_wdata;
   logic [BACK_W-1:0] back_rd;
   logic [AW-1:0]    rd_addr;

   logic             id_in_range;
   logic             rd_listed;
   frame_id_type     rd_back;
   logic             unpin_ok;

   // victim walks from the oldest end, pin and unpin look at their own frame
   assign rd_addr = (cmd_ff == CMD_VICTIM) ? to_addr(head_ff) : to_addr(id_ff);

   lfr_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_FRAMES)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   lfr_ram #(
      .WIDTH (BACK_W),
      .DEPTH (MAX_FRAMES)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (back_waddr),
      .wr_data (back_wdata),
      .rd_addr (rd_addr),
      .rd_data (back_rd)
   );

   assign id_in_range = 32'(id_ff) < 32'(MAX_FRAMES);
   assign rd_listed   = back_rd[ID_W];
   assign rd_back     = back_rd[ID_W-1:0];

   // unpin: below the active limit, inside the ram, not yet listed and room left
   assign unpin_ok = ({1'b0, id_ff} < active_ff) && id_in_range && !rd_listed
                     && (32'(count_ff) < 32'(MAX_FRAMES));

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      clr_in         = clr_ff;
      link_in        = link_ff;
      back_in        = back_ff;
      rsp_fire       = 1'b0;
      rsp_changed_in = 1'b0;
      rsp_victim_in  = '0;
      next_we        = 1'b0;
      next_waddr     = to_addr(tail_ff);
      next_wdata     = id_ff;
      back_we        = 1'b0;
      back_waddr     = to_addr(id_ff);
      back_wdata     = '0;

      case (state_ff)
         S_CLEAR: begin
            // sweep every frame to not listed
            back_we    = 1'b1;
            back_waddr = clr_ff;
            back_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               id_in    = req_frame_id;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // ram read in flight
            state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_fire = 1'b1;
            state_in = S_IDLE;
            case (cmd_ff)
               CMD_VICTIM: begin
                  if (count_ff != '0) begin
                     back_we        = 1'b1;
                     back_waddr     = to_addr(head_ff);
                     back_wdata     = '0;
                     head_in        = next_rd;
                     count_in       = count_ff - 1'b1;
                     rsp_changed_in = 1'b1;
                     rsp_victim_in  = head_ff;
                  end
               end
               CMD_PIN: begin
                  if (id_in_range && rd_listed) begin
                     back_we        = 1'b1;
                     back_waddr     = to_addr(id_ff);
                     back_wdata     = {1'b0, rd_back};
                     count_in       = count_ff - 1'b1;
                     rsp_changed_in = 1'b1;
                     link_in        = next_rd;
                     back_in        = rd_back;
                     // older neighbour skips over the frame
                     if (id_ff != head_ff) begin
                        next_we    = 1'b1;
                        next_waddr = to_addr(rd_back);
                        next_wdata = next_rd;
                     end else begin
                        head_in = next_rd;
                     end
                     // newer neighbour needs its back link fixed in the fix state
                     if (id_ff == tail_ff) begin
                        tail_in = rd_back;
                     end else begin
                        rsp_fire = 1'b0;
                        state_in = S_FIX;
                     end
                  end
               end
               CMD_UNPIN: begin
                  if (unpin_ok) begin
                     back_we    = 1'b1;
                     back_waddr = to_addr(id_ff);
                     back_wdata = {1'b1, tail_ff};
                     if (count_ff != '0) begin
                        next_we    = 1'b1;
                        next_waddr = to_addr(tail_ff);
                        next_wdata = id_ff;
                     end else begin
                        head_in = id_ff;
                     end
                     tail_in        = id_ff;
                     count_in       = count_ff + 1'b1;
                     rsp_changed_in = 1'b1;
                  end
               end
               default: begin
                  // unknown command leaves the list alone
               end
            endcase
         end
         S_FIX: begin
            back_we        = 1'b1;
            back_waddr     = to_addr(link_ff);
            back_wdata     = {1'b1, back_ff};
            rsp_fire       = 1'b1;
            rsp_changed_in = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         active_ff     <= ACTIVE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_fire;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // payload and list pointers without reset; the pointers are meaningful only while count is non-zero
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      head_ff        <= head_in;
      tail_ff        <= tail_in;
      link_ff        <= link_in;
      back_ff        <= back_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_size_ff    <= count_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_victim_frame = rsp_victim_ff;
   assign rsp_list_size    = rsp_size_ff;

endmodule

// ===== hdl/lfr_checker.sv =====
// port level checks for the lru frame replacer and their bind
module lfr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic                      rsp_changed,
   input logic [lfr_pkg::ID_W-1:0]  rsp_victim_frame,
   input logic [lfr_pkg::CNT_W-1:0] rsp_list_size
);

   import lfr_pkg::*;

   logic pending_ff;

   // one request outstanding at most
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (start && !busy) begin
         pending_ff <= 1'b1;
      end else if (rsp_strobe) begin
         pending_ff <= 1'b0;
      end
   end

   a_rsp_needs_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> pending_ff)
      else $error("result without an outstanding request");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted request did not hold the block busy");

   a_rsp_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("block still busy while its result is shown");

   a_victim_implies_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_victim_frame != '0)) |-> rsp_changed)
      else $error("victim frame reported without a change");

   a_size_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_list_size <= SIZE_CAP))
      else $error("list size beyond the frame id space");

endmodule

bind lru_frame_replacer_top lfr_checker u_lfr_checker (.*);
